[sv/msr_pkg.sv]
// Shared types and constants of the modular square root core.
`default_nettype none

package msr_pkg;

    localparam int VALUE_W = 32;
    localparam int MOD_W = 31;
    localparam int ROOT_W = 31;

    // Upper bound of the non-residue search and the width of its counter.
    localparam int NQR_LIMIT = 4096;
    localparam int Z_W = 13;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [MOD_W-1:0]          modulus;
    } msr_in_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              is_residue;
    } msr_out_t;

endpackage

`default_nettype wire

[sv/msr_reduce.sv]
// Bit-serial remainder of a 32-bit magnitude by the modulus.
`default_nettype none

module msr_reduce #(
    parameter int W = 31
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [msr_pkg::VALUE_W-1:0] mag,
    input  wire logic [W-1:0]                p,
    output logic                             done,
    output logic [W-1:0]                     rem
);
    import msr_pkg::*;

    localparam int CW = $clog2(VALUE_W);

    typedef enum logic {
        R_IDLE,
        R_RUN
    } red_state_t;

    red_state_t          state_reg;
    logic [CW-1:0]       cnt_reg;
    logic [VALUE_W-1:0]  mag_reg;
    logic [W-1:0]        rem_reg;
    logic                done_reg;
    logic [W:0]          trial;
    logic [W:0]          diff;
    logic [W-1:0]        rem_next;

    // The partial remainder stays below p, so one conditional subtract suffices.
    always_comb begin
        trial = {rem_reg, mag_reg[VALUE_W-1]};
        diff = trial - {1'b0, p};
        rem_next = (trial >= {1'b0, p}) ? diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                R_IDLE: begin
                    if (start) begin
                        mag_reg <= mag;
                        rem_reg <= '0;
                        cnt_reg <= CW'(VALUE_W - 1);
                        state_reg <= R_RUN;
                    end
                end
                R_RUN: begin
                    rem_reg <= rem_next;
                    mag_reg <= {mag_reg[VALUE_W-2:0], 1'b0};
                    if (cnt_reg == '0) begin
                        done_reg <= 1'b1;
                        state_reg <= R_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign rem = rem_reg;

endmodule

`default_nettype wire

[sv/msr_mulmod.sv]
// Shift-and-add modular multiplier: one modular addition per cycle.
`default_nettype none

module msr_mulmod #(
    parameter int W = 31
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic [W-1:0] p,
    output logic              done,
    output logic [W-1:0]      res
);
    localparam int KW = $clog2(W);

    typedef enum logic [1:0] {
        M_IDLE,
        M_DBL,
        M_ADD
    } mul_state_t;

    mul_state_t     state_reg;
    logic [KW-1:0]  k_reg;
    logic [W-1:0]   a_reg;
    logic [W-1:0]   b_reg;
    logic [W-1:0]   r_reg;
    logic           done_reg;
    logic [W-1:0]   addend;
    logic [W:0]     sum;
    logic [W:0]     diff;
    logic [W-1:0]   r_next;

    // Doubling and adding the multiplicand share one adder and one subtractor.
    always_comb begin
        addend = (state_reg == M_ADD) ? a_reg : r_reg;
        sum = {1'b0, r_reg} + {1'b0, addend};
        diff = sum - {1'b0, p};
        r_next = (sum >= {1'b0, p}) ? diff[W-1:0] : sum[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        a_reg <= a;
                        b_reg <= b;
                        r_reg <= '0;
                        k_reg <= KW'(W - 1);
                        state_reg <= M_DBL;
                    end
                end
                M_DBL: begin
                    r_reg <= r_next;
                    if (b_reg[W-1]) begin
                        state_reg <= M_ADD;
                    end else if (k_reg == '0) begin
                        done_reg <= 1'b1;
                        state_reg <= M_IDLE;
                    end else begin
                        k_reg <= k_reg - 1'b1;
                        b_reg <= {b_reg[W-2:0], 1'b0};
                    end
                end
                M_ADD: begin
                    r_reg <= r_next;
                    if (k_reg == '0) begin
                        done_reg <= 1'b1;
                        state_reg <= M_IDLE;
                    end else begin
                        k_reg <= k_reg - 1'b1;
                        b_reg <= {b_reg[W-2:0], 1'b0};
                        state_reg <= M_DBL;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res = r_reg;

endmodule

`default_nettype wire

[sv/modular_square_root_core.sv]
// Top level: Tonelli-Shanks modular square root sequencer around one shared multiplier.
// The magnitude is first reduced mod p, then each modular product runs on the single
// shift-and-add multiplier, and each exponentiation takes up to 2*PRIME_BITS products;
// for an odd prime a non-residue costs one exponentiation, a residue two when p is 3 mod
// 4, and more under Tonelli-Shanks, chiefly one further exponentiation for every
// candidate non-residue tried.
// Throughput: one item at a time; the next transfer is taken once the result is registered,
// which waits while the previous result is still unaccepted.
// Reset: synchronous, active low; clears the sequencer and the output valid, no clearing pass.
`default_nettype none

module modular_square_root_core #(
    parameter int PRIME_BITS = 31
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire msr_pkg::msr_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output msr_pkg::msr_out_t      m_data
);
    import msr_pkg::*;

    localparam int W = PRIME_BITS;
    localparam int IW = $clog2(W + 1);
    localparam int CW = (W > Z_W) ? W : Z_W;
    localparam logic [W-1:0] ONE_W = W'(1);
    localparam logic [W-1:0] TWO_W = W'(2);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RED, ST_CHECK, ST_POW, ST_POW_ACC, ST_POW_SQ, ST_POW_BASE,
        ST_EULER, ST_ROOT34, ST_FACT, ST_ZTEST, ST_ZCHK, ST_C, ST_T, ST_R,
        ST_TLOOP, ST_ILOOP, ST_ISQ, ST_BLOOP, ST_BSQ, ST_CSQ, ST_TMUL, ST_RMUL,
        ST_DONE
    } seq_state_t;

    seq_state_t          state_reg;
    seq_state_t          pret_reg;
    logic [W-1:0]        p_reg;
    logic [W-1:0]        n_reg;
    logic                neg_reg;
    logic [W-1:0]        pacc_reg;
    logic [W-1:0]        pbase_reg;
    logic [W-1:0]        pexp_reg;
    logic [W-1:0]        q_reg;
    logic [IW-1:0]       s_reg;
    logic [IW-1:0]       m_reg;
    logic [IW-1:0]       i_reg;
    logic [IW-1:0]       cnt_reg;
    logic [Z_W-1:0]      z_reg;
    logic [W-1:0]        c_reg;
    logic [W-1:0]        t_reg;
    logic [W-1:0]        r_reg;
    logic [W-1:0]        b_reg;
    logic [W-1:0]        tmp_reg;
    logic [W-1:0]        root_reg;
    logic                ok_reg;
    logic                mul_start_reg;
    logic [W-1:0]        mul_a_reg;
    logic [W-1:0]        mul_b_reg;
    logic                red_start_reg;
    logic [VALUE_W-1:0]  mag_reg;
    logic                m_valid_reg;
    msr_out_t            m_data_reg;

    logic                mul_done;
    logic [W-1:0]        mul_res;
    logic                red_done;
    logic [W-1:0]        red_rem;

    logic [W+MOD_W-1:0]  mod_ext;
    logic [W-1:0]        p_in;
    logic [W-1:0]        pm1;
    logic [W-1:0]        half_pm1;
    logic [W:0]          pp1;
    logic [W-1:0]        exp34;
    logic [W:0]          qp1;
    logic [W-1:0]        half_qp1;
    logic [CW-1:0]       z_ext;
    logic [CW-1:0]       p_ext;
    logic [W-1:0]        z_w;
    logic [W+ROOT_W-1:0] root_ext;

    always_comb begin
        mod_ext = {{W{1'b0}}, s_data.modulus};
        p_in = mod_ext[W-1:0];
        pm1 = p_reg - ONE_W;
        half_pm1 = pm1 >> 1;
        pp1 = {1'b0, p_reg} + {1'b0, ONE_W};
        exp34 = {1'b0, pp1[W:2]};
        qp1 = {1'b0, q_reg} + {1'b0, ONE_W};
        half_qp1 = qp1[W:1];
        z_ext = CW'(z_reg);
        p_ext = CW'(p_reg);
        z_w = z_ext[W-1:0];
        root_ext = {{ROOT_W{1'b0}}, root_reg};
    end

    msr_reduce #(
        .W(W)
    ) u_reduce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (red_start_reg),
        .mag     (mag_reg),
        .p       (p_reg),
        .done    (red_done),
        .rem     (red_rem)
    );

    msr_mulmod #(
        .W(W)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .p       (p_reg),
        .done    (mul_done),
        .res     (mul_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pret_reg <= ST_IDLE;
            mul_start_reg <= 1'b0;
            red_start_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            red_start_reg <= 1'b0;
            // A finished result replaces the held one as soon as that one is taken.
            if (state_reg == ST_DONE) begin
                if (!m_valid_reg || m_ready) begin
                    m_data_reg.root <= root_ext[ROOT_W-1:0];
                    m_data_reg.is_residue <= ok_reg;
                    m_valid_reg <= 1'b1;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        p_reg <= p_in;
                        neg_reg <= s_data.value[VALUE_W-1];
                        mag_reg <= s_data.value[VALUE_W-1] ?
                                   (~s_data.value + 1'b1) : s_data.value;
                        if (p_in < TWO_W) begin
                            root_reg <= '0;
                            ok_reg <= 1'b0;
                            state_reg <= ST_DONE;
                        end else begin
                            red_start_reg <= 1'b1;
                            state_reg <= ST_RED;
                        end
                    end
                end
                ST_RED: begin
                    if (red_done) begin
                        n_reg <= (neg_reg && red_rem != '0) ? p_reg - red_rem : red_rem;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (n_reg == '0) begin
                        root_reg <= '0;
                        ok_reg <= 1'b1;
                        state_reg <= ST_DONE;
                    end else if (p_reg == TWO_W) begin
                        root_reg <= {{(W-1){1'b0}}, n_reg[0]};
                        ok_reg <= 1'b1;
                        state_reg <= ST_DONE;
                    end else begin
                        pacc_reg <= ONE_W;
                        pbase_reg <= n_reg;
                        pexp_reg <= half_pm1;
                        pret_reg <= ST_EULER;
                        state_reg <= ST_POW;
                    end
                end
                // Right-to-left exponentiation; returns to pret_reg with the power in pacc_reg.
                ST_POW: begin
                    if (pexp_reg == '0) begin
                        state_reg <= pret_reg;
                    end else if (pexp_reg[0]) begin
                        mul_start_reg <= 1'b1;
                        mul_a_reg <= pacc_reg;
                        mul_b_reg <= pbase_reg;
                        state_reg <= ST_POW_ACC;
                    end else begin
                        state_reg <= ST_POW_SQ;
                    end
                end
                ST_POW_ACC: begin
                    if (mul_done) begin
                        pacc_reg <= mul_res;
                        state_reg <= ST_POW_SQ;
                    end
                end
                ST_POW_SQ: begin
                    if ((pexp_reg >> 1) == '0) begin
                        pexp_reg <= '0;
                        state_reg <= ST_POW;
                    end else begin
                        mul_start_reg <= 1'b1;
                        mul_a_reg <= pbase_reg;
                        mul_b_reg <= pbase_reg;
                        state_reg <= ST_POW_BASE;
                    end
                end
                ST_POW_BASE: begin
                    if (mul_done) begin
                        pbase_reg <= mul_res;
                        pexp_reg <= pexp_reg >> 1;
                        state_reg <= ST_POW;
                    end
                end
                ST_EULER: begin
                    if (pacc_reg != ONE_W) begin
                        root_reg <= '0;
                        ok_reg <= 1'b0;
                        state_reg <= ST_DONE;
                    end else if (p_reg[1:0] == 2'b11) begin
                        pacc_reg <= ONE_W;
                        pbase_reg <= n_reg;
                        pexp_reg <= exp34;
                        pret_reg <= ST_ROOT34;
                        state_reg <= ST_POW;
                    end else begin
                        q_reg <= pm1;
                        s_reg <= '0;
                        state_reg <= ST_FACT;
                    end
                end
                ST_ROOT34: begin
                    root_reg <= pacc_reg;
                    ok_reg <= 1'b1;
                    state_reg <= ST_DONE;
                end
                // Strip the factors of two from p-1, one per cycle.
                ST_FACT: begin
                    if (q_reg != '0 && !q_reg[0]) begin
                        q_reg <= q_reg >> 1;
                        s_reg <= s_reg + 1'b1;
                    end else begin
                        z_reg <= Z_W'(2);
                        state_reg <= ST_ZTEST;
                    end
                end
                ST_ZTEST: begin
                    if (z_ext >= p_ext || z_reg > Z_W'(NQR_LIMIT)) begin
                        root_reg <= '0;
                        ok_reg <= 1'b0;
                        state_reg <= ST_DONE;
                    end else begin
                        pacc_reg <= ONE_W;
                        pbase_reg <= z_w;
                        pexp_reg <= half_pm1;
                        pret_reg <= ST_ZCHK;
                        state_reg <= ST_POW;
                    end
                end
                ST_ZCHK: begin
                    if (pacc_reg == pm1) begin
                        pacc_reg <= ONE_W;
                        pbase_reg <= z_w;
                        pexp_reg <= q_reg;
                        pret_reg <= ST_C;
                        state_reg <= ST_POW;
                    end else begin
                        z_reg <= z_reg + 1'b1;
                        state_reg <= ST_ZTEST;
                    end
                end
                ST_C: begin
                    c_reg <= pacc_reg;
                    m_reg <= s_reg;
                    pacc_reg <= ONE_W;
                    pbase_reg <= n_reg;
                    pexp_reg <= q_reg;
                    pret_reg <= ST_T;
                    state_reg <= ST_POW;
                end
                ST_T: begin
                    t_reg <= pacc_reg;
                    pacc_reg <= ONE_W;
                    pbase_reg <= n_reg;
                    pexp_reg <= half_qp1;
                    pret_reg <= ST_R;
                    state_reg <= ST_POW;
                end
                ST_R: begin
                    r_reg <= pacc_reg;
                    state_reg <= ST_TLOOP;
                end
                ST_TLOOP: begin
                    if (t_reg == ONE_W) begin
                        root_reg <= r_reg;
                        ok_reg <= 1'b1;
                        state_reg <= ST_DONE;
                    end else begin
                        i_reg <= '0;
                        tmp_reg <= t_reg;
                        state_reg <= ST_ILOOP;
                    end
                end
                // Find the least i with t^(2^i) equal to one.
                ST_ILOOP: begin
                    if (tmp_reg == ONE_W) begin
                        b_reg <= c_reg;
                        cnt_reg <= m_reg - i_reg - 1'b1;
                        state_reg <= ST_BLOOP;
                    end else if (i_reg + 1'b1 >= m_reg) begin
                        root_reg <= '0;
                        ok_reg <= 1'b0;
                        state_reg <= ST_DONE;
                    end else begin
                        mul_start_reg <= 1'b1;
                        mul_a_reg <= tmp_reg;
                        mul_b_reg <= tmp_reg;
                        state_reg <= ST_ISQ;
                    end
                end
                ST_ISQ: begin
                    if (mul_done) begin
                        tmp_reg <= mul_res;
                        i_reg <= i_reg + 1'b1;
                        state_reg <= ST_ILOOP;
                    end
                end
                ST_BLOOP: begin
                    mul_start_reg <= 1'b1;
                    mul_a_reg <= b_reg;
                    mul_b_reg <= b_reg;
                    if (cnt_reg == '0) begin
                        m_reg <= i_reg;
                        state_reg <= ST_CSQ;
                    end else begin
                        state_reg <= ST_BSQ;
                    end
                end
                ST_BSQ: begin
                    if (mul_done) begin
                        b_reg <= mul_res;
                        cnt_reg <= cnt_reg - 1'b1;
                        state_reg <= ST_BLOOP;
                    end
                end
                ST_CSQ: begin
                    if (mul_done) begin
                        c_reg <= mul_res;
                        mul_start_reg <= 1'b1;
                        mul_a_reg <= t_reg;
                        mul_b_reg <= mul_res;
                        state_reg <= ST_TMUL;
                    end
                end
                ST_TMUL: begin
                    if (mul_done) begin
                        t_reg <= mul_res;
                        mul_start_reg <= 1'b1;
                        mul_a_reg <= r_reg;
                        mul_b_reg <= b_reg;
                        state_reg <= ST_RMUL;
                    end
                end
                ST_RMUL: begin
                    if (mul_done) begin
                        r_reg <= mul_res;
                        state_reg <= ST_TLOOP;
                    end
                end
                // The result waits here until the output register is free.
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule

`default_nettype wire

[bench/modular_square_root_core_test.sv]
// Self-checking testbench of the modular square root core, with its own predictor.
`default_nettype none

module modular_square_root_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import msr_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1_000_000;
    localparam int unsigned TAIL_CYCLES = 200;
    localparam int unsigned ITEMS_PER_PHASE = 32;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    msr_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    msr_out_t m_data;

    msr_in_t     pending_items[$];
    msr_out_t    sqrt_expected[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    modular_square_root_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Operands stay below 2^31, so the full product fits in 64 bits.
    function automatic longint unsigned prod_mod(longint unsigned a, longint unsigned b,
                                                 longint unsigned p);
        return (a * b) % p;
    endfunction

    function automatic longint unsigned exp_mod(longint unsigned base, longint unsigned e,
                                                longint unsigned p);
        longint unsigned acc;
        acc = 1 % p;
        base = base % p;
        while (e != 0) begin
            if (e[0])
                acc = prod_mod(acc, base, p);
            base = prod_mod(base, base, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Expected result of one input transfer.
    function automatic msr_out_t predict_sqrt(msr_in_t item);
        longint unsigned p, n, q, z, c, t, r, b, tmp, rem;
        longint          v;
        int unsigned     s, m, i, j;
        msr_out_t        res;
        res = '0;
        p = 64'(item.modulus);
        v = item.value;
        if (p < 2)
            return res;
        if (v >= 0) begin
            n = longint'(v) % p;
        end else begin
            rem = longint'(-v) % p;
            n = (rem != 0) ? p - rem : 0;
        end
        res.is_residue = 1'b1;
        if (n == 0)
            return res;
        if (p == 2) begin
            res.root = ROOT_W'(n & 1);
            return res;
        end
        if (exp_mod(n, (p - 1) / 2, p) != 1)
            return '0;
        if ((p & 3) == 3) begin
            res.root = ROOT_W'(exp_mod(n, (p + 1) / 4, p));
            return res;
        end

        q = p - 1;
        s = 0;
        while (q != 0 && !q[0]) begin
            q = q >> 1;
            s++;
        end
        // Smallest non-residue, with the same give-up bounds as the hardware search.
        z = 2;
        while (exp_mod(z, (p - 1) / 2, p) != p - 1) begin
            if (z >= p || z > NQR_LIMIT)
                return '0;
            z++;
        end
        if (z >= p || z > NQR_LIMIT)
            return '0;

        m = s;
        c = exp_mod(z, q, p);
        t = exp_mod(n, q, p);
        r = exp_mod(n, (q + 1) / 2, p);
        while (t != 1) begin
            i = 0;
            tmp = t;
            while (tmp != 1) begin
                if (i + 1 >= m)
                    return '0;
                tmp = prod_mod(tmp, tmp, p);
                i++;
            end
            b = c;
            for (j = 0; j + i + 1 < m; j++)
                b = prod_mod(b, b, p);
            m = i;
            c = prod_mod(b, b, p);
            t = prod_mod(t, c, p);
            r = prod_mod(r, b, p);
        end
        res.root = ROOT_W'(r);
        return res;
    endfunction

    // Miller-Rabin with bases 2 to 7 is exact for every modulus of 31 bits.
    function automatic bit is_prime(longint unsigned n);
        longint unsigned d, x, a;
        int unsigned     r, k;
        bit              witness;
        if (n < 2)
            return 1'b0;
        for (a = 2; a <= 37; a++) begin
            if (n == a)
                return 1'b1;
            if (n % a == 0)
                return 1'b0;
        end
        d = n - 1;
        r = 0;
        while (!d[0]) begin
            d = d >> 1;
            r++;
        end
        for (a = 2; a <= 7; a++) begin
            x = exp_mod(a, d, n);
            witness = (x != 1 && x != n - 1);
            for (k = 1; k < r && witness; k++) begin
                x = prod_mod(x, x, n);
                if (x == n - 1)
                    witness = 1'b0;
            end
            if (witness)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic longint unsigned pick_prime(longint unsigned lo, longint unsigned hi);
        longint unsigned p;
        p = lo + longint'($urandom_range(32'(hi - lo), 0));
        // Both residue classes mod 4, so both the short path and full Tonelli-Shanks are hit.
        p = (p & ~64'd3) | ($urandom_range(1) ? 64'd1 : 64'd3);
        while (!is_prime(p))
            p = p + 4;
        return p;
    endfunction

    // Mostly squares mod p, shifted by random multiples of p across the signed range.
    function automatic logic [31:0] value_for(longint unsigned p);
        longint unsigned x, sq;
        longint          v;
        int unsigned     sel, k;
        sel = $urandom_range(99);
        if (p < 2 || sel >= 55)
            return $urandom;
        x = longint'($urandom) % p;
        sq = (sel < 6) ? 0 : prod_mod(x, x, p);
        if ($urandom_range(1)) begin
            k = $urandom_range(32'(64'd2147483648 / p), 0);
            v = longint'(sq) - longint'(p) * longint'(k);
        end else begin
            k = $urandom_range(32'((64'd2147483647 - sq) / p), 0);
            v = longint'(sq) + longint'(p) * longint'(k);
        end
        return v[31:0];
    endfunction

    function automatic msr_in_t random_item();
        msr_in_t         item;
        int unsigned     sel;
        longint unsigned p;
        sel = $urandom_range(99);
        if (sel < 3)
            p = 2;
        else if (sel < 12)
            p = $urandom_range(1) ? longint'($urandom_range(200, 0))
                                  : longint'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000) | 3);
        else if (sel < 37)
            p = pick_prime(3, 250);
        else if (sel < 70)
            p = pick_prime(257, 65000);
        else
            p = pick_prime(64'h4000_0000, 64'h7FEF_FFFF);
        item.modulus = p[MOD_W-1:0];
        item.value = value_for(p);
        return item;
    endfunction

    task automatic queue_item(input longint v, input longint unsigned p);
        msr_in_t item;
        item.value = v[31:0];
        item.modulus = p[MOD_W-1:0];
        pending_items.push_back(item);
    endtask

    // Sampled mid-cycle, so that an item still on the input port counts as in flight.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || sqrt_expected.size() != 0)
            @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        msr_out_t want;
        if (aresetn && s_valid && s_ready)
            sqrt_expected.push_back(predict_sqrt(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (sqrt_expected.size() == 0) begin
                $error("result transfer with no outstanding item: root %0d, is_residue %0b",
                       m_data.root, m_data.is_residue);
                mismatches++;
            end else begin
                want = sqrt_expected.pop_front();
                if (m_data.root !== want.root) begin
                    $error("root mismatch: expected %0d, got %0d", want.root, m_data.root);
                    mismatches++;
                end
                if (m_data.is_residue !== want.is_residue) begin
                    $error("is_residue mismatch: expected %0b, got %0b",
                           want.is_residue, m_data.is_residue);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int unsigned phase;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        queue_item(0, 7);
        queue_item(-14, 7);
        queue_item(32'sh7FFF_FFFF, 2);
        queue_item(longint'(32'sh8000_0000), 2);
        queue_item(-1, 2);
        queue_item(5, 0);
        queue_item(-5, 1);
        queue_item(2, 3);
        queue_item(-3, 7);
        queue_item(32'sh7FFF_FFFF, 32'h7FFF_FFFF);
        queue_item(longint'(32'sh8000_0000), 32'h7FFF_FFFF);
        queue_item(prod_mod(1234567, 1234567, 32'h7FFF_FFFF), 32'h7FFF_FFFF);
        queue_item(10, 13);
        queue_item(2, 17);
        queue_item(-1, 5);
        queue_item(2, 5);
        // A prime with a large power of two in p-1 and a late non-residue.
        queue_item(prod_mod(123456789, 123456789, 2013265921), 2013265921);
        queue_item(31, 2013265921);
        queue_item(-7, 998244353);
        queue_item(prod_mod(4242, 4242, 65537), 65537);
        // Composite moduli, on which the core and the predictor run the same steps as for a prime.
        queue_item(7, 9);
        queue_item(4, 15);
        queue_item(1, 4);
        queue_item(4, 2147483643);
        queue_item(3, 8);
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            repeat (ITEMS_PER_PHASE)
                pending_items.push_back(random_item());
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
